/* rtl/core/tlbrhc_pkg.sv */
`default_nettype none

package tlbrhc_pkg;

   localparam int TLB_ENTRIES_DEF = 64;
   localparam int PAGE_BITS_DEF   = 32;

   localparam int FIELD_W = 32;
   localparam int CAP_W   = 7;
   localparam int POL_W   = 2;
   localparam int CSR_W   = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [POL_W-1:0] POLICY_FIFO = 2'd0;
   localparam logic [POL_W-1:0] POLICY_LIFO = 2'd1;
   localparam logic [POL_W-1:0] POLICY_LRU  = 2'd2;

   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_POLICY   = 1'b1;

   typedef struct packed {
      logic [FIELD_W-1:0] page_number;
      logic               last_in_trace;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [FIELD_W-1:0] hit_count;
      logic               evicted_valid;
      logic [FIELD_W-1:0] evicted_page;
   } rsp_type;

   typedef struct packed {
      logic               hit;
      logic               evicted_valid;
      logic [FIELD_W-1:0] evicted_page;
   } lookup_type;

endpackage

`default_nettype wire

/* rtl/core/tlbrhc_store.sv */
`default_nettype none

module tlbrhc_store #(
   parameter int TLB_ENTRIES = tlbrhc_pkg::TLB_ENTRIES_DEF,
   parameter int PAGE_BITS   = tlbrhc_pkg::PAGE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step,
   input  wire tlbrhc_pkg::req_type                req,
   input  wire logic [tlbrhc_pkg::CAP_W-1:0]       capacity,
   input  wire logic [tlbrhc_pkg::POL_W-1:0]       policy,
   output tlbrhc_pkg::lookup_type                  result
);

   localparam int SW = (PAGE_BITS < tlbrhc_pkg::FIELD_W) ? PAGE_BITS : tlbrhc_pkg::FIELD_W;
   localparam int CW = $clog2(TLB_ENTRIES + 1);
   localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int KW = 9;

   logic [SW-1:0] pages_ff [TLB_ENTRIES];
   logic [SW-1:0] pages_in [TLB_ENTRIES];
   logic [SW-1:0] up_pages [TLB_ENTRIES];
   logic [CW-1:0] occ_ff;
   logic [CW-1:0] occ_in;

   logic [SW-1:0]          page;
   logic [TLB_ENTRIES-1:0] match;
   logic [IW-1:0]          where;
   logic                   found;
   logic                   lifo;
   logic                   lru;
   logic [KW-1:0]          cap_wide;
   logic [CW-1:0]          cap_eff;
   logic                   full;
   logic                   evict;
   logic                   rm;
   logic [IW-1:0]          pos;
   logic [CW-1:0]          occ_m1;
   logic                   app;
   logic [CW-1:0]          occ_after;
   logic                   app_ok;
   logic [IW-1:0]          app_idx;

   assign page = req.page_number[SW-1:0];
   assign lifo = (policy == tlbrhc_pkg::POLICY_LIFO);
   assign lru  = (policy == tlbrhc_pkg::POLICY_LRU);

   always_comb begin
      cap_wide = {{(KW - tlbrhc_pkg::CAP_W){1'b0}}, capacity};
      if (cap_wide == '0) begin
         cap_wide = KW'(1);
      end else if (cap_wide > KW'(TLB_ENTRIES)) begin
         cap_wide = KW'(TLB_ENTRIES);
      end
      cap_eff = cap_wide[CW-1:0];
   end

   always_comb begin
      where = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         match[i] = (CW'(i) < occ_ff) && (pages_ff[i] == page);
         if (match[i]) begin
            where = where | IW'(i);
         end
      end
   end

   assign found  = |match;
   assign full   = (occ_ff >= cap_eff) && (occ_ff != '0);
   assign evict  = !found && full;
   assign occ_m1 = occ_ff - CW'(1);

   always_comb begin
      if (found) begin
         pos = where;
      end else if (lifo) begin
         pos = occ_m1[IW-1:0];
      end else begin
         pos = '0;
      end
   end

   assign rm        = evict || (found && lru);
   assign app       = !found || lru;
   assign occ_after = occ_ff - CW'(rm);
   assign app_ok    = app && (occ_after < CW'(TLB_ENTRIES));
   assign app_idx   = occ_after[IW-1:0];

   for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_up
      if (g < TLB_ENTRIES - 1) begin : g_mid
         assign up_pages[g] = pages_ff[g+1];
      end else begin : g_top
         assign up_pages[g] = pages_ff[g];
      end
   end

   always_comb begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (app_ok && (IW'(i) == app_idx)) begin
            pages_in[i] = page;
         end else if (rm && (IW'(i) >= pos)) begin
            pages_in[i] = up_pages[i];
         end else begin
            pages_in[i] = pages_ff[i];
         end
      end
      occ_in = occ_after + CW'(app_ok);
   end

   always_comb begin
      result.hit           = found;
      result.evicted_valid = evict;
      result.evicted_page  = evict ? tlbrhc_pkg::FIELD_W'(pages_ff[pos]) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (step) begin
         occ_ff <= req.last_in_trace ? '0 : occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            pages_ff[i] <= pages_in[i];
         end
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(TLB_ENTRIES))
      else $error("occupancy above depth");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step && req.last_in_trace |=> occ_ff == '0)
      else $error("store not cleared after last word");

   a_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("page held twice");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      result.evicted_valid |-> !result.hit && occ_ff >= cap_eff)
      else $error("eviction without full store");

   a_hit_keeps: assert property (@(posedge clock) disable iff (reset)
      step && found && !req.last_in_trace |=> occ_ff == $past(occ_ff))
      else $error("hit changed occupancy");

endmodule

`default_nettype wire

/* rtl/core/tlb_replacement_hit_counter.sv */
`default_nettype none

// Channel  Ports                            Direction  Moves
// req      req_valid/req_ready/req_word     in         page number, last flag
// rsp      rsp_valid/rsp_ready/rsp_word     out        hit, hit count, eviction
// csr      csr_we/csr_index/csr_wdata       in         capacity, policy writes
//
// One word per cycle while rsp is not stalled: lookup, eviction and the ordered
// shift of the entries above the removed one finish between the input and output registers.
// After req accept, a word passes the input register and then the output register before rsp_valid rises.
// Reset empties the store and hit count, capacity 64, policy FIFO.
// A stalled rsp holds its word; req takes one more word into the input
// register and then stalls until rsp moves.

module tlb_replacement_hit_counter #(
   parameter int TLB_ENTRIES = tlbrhc_pkg::TLB_ENTRIES_DEF,
   parameter int PAGE_BITS   = tlbrhc_pkg::PAGE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire tlbrhc_pkg::req_type            req_word,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output tlbrhc_pkg::rsp_type                 rsp_word,
   input  wire logic                           csr_we,
   input  wire logic                           csr_index,
   input  wire logic [tlbrhc_pkg::CSR_W-1:0]   csr_wdata
);

   logic                                  in_valid_ff;
   tlbrhc_pkg::req_type                   in_word_ff;
   logic                                  out_valid_ff;
   tlbrhc_pkg::rsp_type                   out_word_ff;
   tlbrhc_pkg::rsp_type                   out_word_in;
   logic [tlbrhc_pkg::CAP_W-1:0]          capacity_ff;
   logic [tlbrhc_pkg::POL_W-1:0]          policy_ff;
   logic [tlbrhc_pkg::FIELD_W-1:0]        hits_ff;
   logic [tlbrhc_pkg::FIELD_W-1:0]        hits_in;
   logic                                  advance;
   logic                                  step;
   tlbrhc_pkg::lookup_type                lookup;

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   tlbrhc_store #(
      .TLB_ENTRIES(TLB_ENTRIES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .req     (in_word_ff),
      .capacity(capacity_ff),
      .policy  (policy_ff),
      .result  (lookup)
   );

   always_comb begin
      hits_in = hits_ff;
      if (lookup.hit && (hits_ff != '1)) begin
         hits_in = hits_ff + tlbrhc_pkg::FIELD_W'(1);
      end
      out_word_in.hit           = lookup.hit;
      out_word_in.hit_count     = hits_in;
      out_word_in.evicted_valid = lookup.evicted_valid;
      out_word_in.evicted_page  = lookup.evicted_page;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= tlbrhc_pkg::CAP_RESET;
         policy_ff   <= tlbrhc_pkg::POLICY_FIFO;
      end else if (csr_we) begin
         case (csr_index)
            tlbrhc_pkg::CSR_CAPACITY: capacity_ff <= csr_wdata[tlbrhc_pkg::CAP_W-1:0];
            tlbrhc_pkg::CSR_POLICY:   policy_ff   <= csr_wdata[tlbrhc_pkg::POL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff <= '0;
      end else if (step) begin
         hits_ff <= in_word_ff.last_in_trace ? '0 : hits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (step) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

`default_nettype wire
